// ===== hw/rtl/phpa_pkg.sv =====
// Shared types, codes and defaults of the per-hart page allocator.
// Used by every module of the allocator; depends on nothing else.
package phpa_pkg;

  localparam int unsigned NUM_HARTS_DEF  = 8;
  localparam int unsigned MAX_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_STOP_RST  = 32'h8800_0000;

  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_STOP  = 1'b1;

  localparam logic MODE_FREE  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic {
    BK_EXEC,
    BK_POP
  } back_state_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  hart;
    logic        bad;
    logic [31:0] pnum;
  } req_t;

  function automatic logic [2:0] hart_wrap(logic [2:0] h, int unsigned n);
    logic [31:0] w;
    w = 32'(h);
    for (int i = 0; i < 8; i++) begin
      if (w >= n) begin
        w = w - n;
      end
    end
    return w[2:0];
  endfunction

endpackage

// ===== hw/rtl/phpa_front.sv =====
// Request front end: registers an incoming transaction, checks the free
// address against the region and forms the page number. Uses phpa_pkg.
module phpa_front #(
  parameter int unsigned NUM_HARTS  = phpa_pkg::NUM_HARTS_DEF,
  parameter int unsigned PAGE_BYTES = phpa_pkg::PAGE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            mode,
  input  logic [2:0]      hart,
  input  logic [31:0]     page_addr,
  input  logic [31:0]     region_start,
  input  logic [31:0]     region_stop,
  output logic            q_push,
  output phpa_pkg::req_t  q_data,
  input  logic            q_full
);

  localparam int unsigned PBW = $clog2(PAGE_BYTES);

  logic        fv;
  logic        f_mode;
  logic [2:0]  f_hart;
  logic [31:0] f_addr;
  logic [31:0] base;
  logic [31:0] diff;
  logic        accept;

  assign q_push   = fv && !q_full;
  assign in_ready = !fv || q_push;
  assign accept   = in_valid && in_ready;

  assign base = {region_start[31:PBW], PBW'(0)};
  assign diff = f_addr - base;

  always_comb begin
    q_data      = '0;
    q_data.mode = f_mode;
    q_data.hart = f_hart;
    q_data.bad  = (f_addr[PBW-1:0] != '0) || (f_addr < region_start) ||
                  (f_addr >= region_stop);
    q_data.pnum = {PBW'(0), diff[31:PBW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_mode <= mode;
      f_hart <= phpa_pkg::hart_wrap(hart, NUM_HARTS);
      f_addr <= page_addr;
    end
  end

endmodule

// ===== hw/rtl/phpa_queue.sv =====
// Short request queue between the front end and the stack engine.
// Holds phpa_pkg::req_t entries.
module phpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  phpa_pkg::req_t  push_data,
  output logic            full,
  input  logic            pop,
  output phpa_pkg::req_t  pop_data,
  output logic            q_valid
);

  localparam int unsigned DEPTH = phpa_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  phpa_pkg::req_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && q_valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/phpa_back.sv =====
// Stack engine: per-hart free stack heads, the next-page memory and the
// result register. Uses phpa_pkg.
module phpa_back #(
  parameter int unsigned NUM_HARTS  = phpa_pkg::NUM_HARTS_DEF,
  parameter int unsigned MAX_PAGES  = phpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = phpa_pkg::PAGE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  phpa_pkg::req_t  q_data,
  output logic            q_pop,
  input  logic [31:0]     region_start,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     alloc_addr,
  output logic [1:0]      status
);

  localparam int unsigned PBW = $clog2(PAGE_BYTES);
  localparam int unsigned PNW = 32 - PBW;
  localparam int unsigned IW  = $clog2(MAX_PAGES);
  localparam int unsigned HW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned HIW = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
  localparam logic [HW-1:0] EMPTY = HW'(MAX_PAGES);

  phpa_pkg::back_state_t state, state_next;

  logic [HW-1:0]  heads [NUM_HARTS];
  logic [HW-1:0]  mem [MAX_PAGES];
  logic [HW-1:0]  rd_data;
  logic [HIW-1:0] pop_hart;

  logic [NUM_HARTS-1:0] ne;
  logic [HIW-1:0]       h;
  logic [HIW-1:0]       first;
  logic                 found;
  logic [HIW-1:0]       t;
  logic [HW-1:0]        top;
  logic                 take;
  logic                 is_free;
  logic                 free_ok;
  logic                 push_ok;
  logic                 hit;
  logic [PNW-1:0]       addr_hi;
  logic [31:0]          res_addr;
  phpa_pkg::status_t    res_status;

  always_comb begin
    for (int i = 0; i < NUM_HARTS; i++) begin
      ne[i] = (heads[i] != EMPTY);
    end
    found = 1'b0;
    first = '0;
    for (int i = NUM_HARTS - 1; i >= 0; i--) begin
      if (ne[i]) begin
        found = 1'b1;
        first = HIW'(i);
      end
    end
  end

  assign h       = HIW'(q_data.hart);
  assign is_free = (q_data.mode == phpa_pkg::MODE_FREE);
  assign t       = (is_free || ne[h]) ? h : first;
  assign top     = heads[t];
  assign free_ok = !q_data.bad && (q_data.pnum < 32'(MAX_PAGES));
  assign hit     = !is_free && (ne[h] || found);
  assign addr_hi = region_start[31:PBW] + PNW'(top[IW-1:0]);
  assign q_pop   = take;

  always_comb begin
    take       = (state == phpa_pkg::BK_EXEC) && q_valid && (!out_valid || out_ready);
    push_ok    = take && is_free && free_ok;
    state_next = state;
    res_addr   = '0;
    res_status = phpa_pkg::ST_OK;
    if (is_free) begin
      if (!free_ok) begin
        res_status = phpa_pkg::ST_BAD;
      end
    end else if (hit) begin
      res_addr = {addr_hi, PBW'(0)};
    end else begin
      res_status = phpa_pkg::ST_OOM;
    end
    unique case (state)
      phpa_pkg::BK_EXEC: begin
        if (take && hit) begin
          state_next = phpa_pkg::BK_POP;
        end
      end
      phpa_pkg::BK_POP: begin
        state_next = phpa_pkg::BK_EXEC;
      end
      default: begin
        state_next = phpa_pkg::BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phpa_pkg::BK_EXEC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      alloc_addr <= res_addr;
      status     <= res_status;
      pop_hart   <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HARTS; i++) begin
        heads[i] <= EMPTY;
      end
    end else if (push_ok) begin
      heads[h] <= HW'(q_data.pnum[IW-1:0]);
    end else if (state == phpa_pkg::BK_POP) begin
      heads[pop_hart] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[q_data.pnum[IW-1:0]] <= top;
    end
    rd_data <= mem[top[IW-1:0]];
  end

`ifndef SYNTHESIS
  a_no_take_in_pop: assert property (@(posedge clk) disable iff (rst)
    state == phpa_pkg::BK_POP |-> !take)
    else $error("request taken while a pop is in flight");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken request produced no result");

  a_hit_enters_pop: assert property (@(posedge clk) disable iff (rst)
    (take && hit) |=> state == phpa_pkg::BK_POP)
    else $error("successful alloc did not update its stack head");
`endif

endmodule

// ===== hw/rtl/per_hart_page_allocator_steal.sv =====
// Per-hart page allocator with stealing: one LIFO free stack per hart.
// Throughput: one free or rejected request per cycle while out_ready keeps up;
// an alloc that pops holds off the next request while the registered read of
// the next-page memory updates the head.
// Reset: synchronous; all stacks empty, region registers to their defaults,
// next-page memory is not cleared.
module per_hart_page_allocator_steal #(
  parameter int unsigned NUM_HARTS  = phpa_pkg::NUM_HARTS_DEF,
  parameter int unsigned MAX_PAGES  = phpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = phpa_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [2:0]  hart,
  input  logic [31:0] page_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] alloc_addr,
  output logic [1:0]  status
);

  logic [31:0]    region_start;
  logic [31:0]    region_stop;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  phpa_pkg::req_t push_data;
  phpa_pkg::req_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= phpa_pkg::REGION_START_RST;
      region_stop  <= phpa_pkg::REGION_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phpa_pkg::CFG_REGION_START: region_start <= cfg_data;
        phpa_pkg::CFG_REGION_STOP:  region_stop  <= cfg_data;
        default: ;
      endcase
    end
  end

  phpa_front #(
    .NUM_HARTS  (NUM_HARTS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .hart         (hart),
    .page_addr    (page_addr),
    .region_start (region_start),
    .region_stop  (region_stop),
    .q_push       (q_push),
    .q_data       (push_data),
    .q_full       (q_full)
  );

  phpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .q_valid   (q_valid)
  );

  phpa_back #(
    .NUM_HARTS  (NUM_HARTS),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .region_start (region_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .alloc_addr   (alloc_addr),
    .status       (status)
  );

endmodule
